@@ src/pdfb_pkg.sv @@
// ----------------------------------------------------------------------------
// pdfb_pkg
// Shared constants and types of the page framebuffer draw engine.
// ----------------------------------------------------------------------------
package pdfb_pkg;

  localparam int WIDTH         = 128;
  localparam int PAGES         = 8;
  localparam int ROWS_PER_PAGE = 8;
  localparam int DEPTH         = PAGES * WIDTH;
  localparam int AW            = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ROWS          = PAGES * ROWS_PER_PAGE;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef enum logic [1:0] {
    FN_FILL  = 2'd0,
    FN_PIXEL = 2'd1,
    FN_GLYPH = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_RDA,
    S_MOD,
    S_WRB,
    S_DONE
  } state_t;

endpackage

@@ src/pdfb_ram.sv @@
// ----------------------------------------------------------------------------
// pdfb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pdfb_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/page_framebuffer_draw_engine_top.sv @@
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_top
// Monochrome page-organised frame store with fill, pixel, glyph column and
// byte read commands, built around one RAM and a small sequencer.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | func, column, row, color, value
//   out_    | output    | out_valid/out_ready | status, read_value
//
// An out-of-range command goes straight to its result. Pixel and glyph
// column commands read the byte and write it back changed, a split glyph
// column also the byte in the next page; byte read only reads. Fill writes
// every address. A new command is taken only once the last one is done.
// After reset a clearing pass zeroes the store; no item is taken meanwhile.
// A held result stalls the sequencer in its last state until out_ready.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_top
  import pdfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [6:0] in_column,
  input  logic [5:0] in_row,
  input  logic       in_color,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_status,
  output logic [7:0] out_read_value
);

  state_t        state_r,  state_nxt;
  func_t         func_r,   func_nxt;
  logic          color_r,  color_nxt;
  logic [7:0]    val_r,    val_nxt;
  logic [2:0]    sh_r,     sh_nxt;
  logic [AW-1:0] addr_a_r, addr_a_nxt;
  logic [AW-1:0] addr_b_r, addr_b_nxt;
  logic [AW-1:0] cnt_r,    cnt_nxt;
  logic          status_r, status_nxt;
  logic [7:0]    rd_r,     rd_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r, out_status_nxt;
  logic [7:0]    out_rd_r, out_rd_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [2:0]    in_page;
  logic          coords_ok;
  logic          split_bad;
  logic [7:0]    lowmask;
  logic [7:0]    pix_bit;
  logic [3:0]    rsh;

  assign in_page   = in_row[5:3];
  assign coords_ok = (32'(in_column) < WIDTH) && (32'(in_row) < ROWS);
  assign split_bad = (func_t'(in_func) == FN_GLYPH) && (in_row[2:0] != 3'd0)
                     && ((32'(in_page) + 32'd1) >= PAGES);
  assign lowmask   = (8'd1 << sh_r) - 8'd1;
  assign pix_bit   = 8'd1 << sh_r;
  assign rsh       = 4'd8 - {1'b0, sh_r};

  pdfb_ram #(
    .DW    (8),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      val_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      val_r       <= val_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    color_r      <= color_nxt;
    sh_r         <= sh_nxt;
    addr_a_r     <= addr_a_nxt;
    addr_b_r     <= addr_b_nxt;
    status_r     <= status_nxt;
    rd_r         <= rd_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    color_nxt      = color_r;
    val_nxt        = val_r;
    sh_nxt         = sh_r;
    addr_a_nxt     = addr_a_r;
    addr_b_nxt     = addr_b_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    rd_nxt         = rd_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = addr_a_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = addr_a_r;

    unique case (state_r)
      S_CLEAR, S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + AW'(1);
        if (32'(cnt_r) == DEPTH - 1) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == S_CLEAR) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt   = func_t'(in_func);
          color_nxt  = in_color;
          val_nxt    = in_value;
          sh_nxt     = in_row[2:0];
          addr_a_nxt = AW'(32'(in_page) * WIDTH + 32'(in_column));
          addr_b_nxt = AW'((32'(in_page) + 32'd1) * WIDTH + 32'(in_column));
          status_nxt = ST_OK;
          rd_nxt     = 8'd0;
          cnt_nxt    = '0;
          if (func_t'(in_func) == FN_FILL) begin
            state_nxt = S_FILL;
          end else if (!coords_ok || split_bad) begin
            status_nxt = ST_RANGE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_RDA;
          end
        end
      end
      S_RDA: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        state_nxt = S_DONE;
        case (func_r)
          FN_PIXEL: begin
            ram_we    = 1'b1;
            ram_wdata = color_r ? (ram_rdata | pix_bit) : (ram_rdata & ~pix_bit);
          end
          FN_GLYPH: begin
            ram_we    = 1'b1;
            ram_wdata = (val_r << sh_r) | (ram_rdata & lowmask);
            if (sh_r != 3'd0) begin
              ram_raddr = addr_b_r;
              state_nxt = S_WRB;
            end
          end
          FN_READ: begin
            rd_nxt = ram_rdata;
          end
          default: begin
            rd_nxt = 8'd0;
          end
        endcase
      end
      S_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b_r;
        ram_wdata = (val_r >> rsh) | (ram_rdata & ~lowmask);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_rd_nxt     = rd_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_rd_r;

endmodule

@@ dv/tb_page_framebuffer_draw_engine_top.sv @@
// ----------------------------------------------------------------------------
// tb_page_framebuffer_draw_engine_top
// Self-checking bench for the page framebuffer draw engine. A directed table
// covers reads after reset, pixel set and clear, aligned and split glyph
// columns, the last-page range error and fill. Random commands follow, with
// a shadow copy of the frame store predicting every status and read byte.
// Both handshakes idle in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_draw_engine_top
  import pdfb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CMDS  = 1700;
  localparam int CALM_TAIL    = 300;
  localparam int STALL_LIMIT  = 8000;
  localparam int SETTLE_TICKS = 20;

  typedef struct packed {
    func_t      func;
    logic [6:0] column;
    logic [5:0] row;
    logic       color;
    logic [7:0] value;
  } draw_cmd_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_value;
  } draw_result_t;

  typedef struct {
    draw_cmd_t    cmd;
    bit           typed;
    draw_result_t result;
  } directed_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_func;
  logic [6:0] in_column;
  logic [5:0] in_row;
  logic       in_color;
  logic [7:0] in_value;
  logic       out_valid;
  logic       out_ready;
  logic       out_status;
  logic [7:0] out_read_value;

  logic [7:0]   shadow_frame [DEPTH];
  draw_result_t expected_results [$];
  directed_row_t directed_rows [];
  bit           idle_on;
  int           error_count;
  int           stall_cycles;

  page_framebuffer_draw_engine_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_color       (in_color),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic draw_result_t apply_draw_cmd(input draw_cmd_t c);
    draw_result_t r;
    int unsigned  page;
    int unsigned  shift;
    int unsigned  lo_addr;
    int unsigned  hi_addr;
    logic [15:0]  spread;
    logic [7:0]   keep_mask;
    r       = '{status: ST_OK, read_value: 8'h00};
    page    = c.row / ROWS_PER_PAGE;
    shift   = c.row % ROWS_PER_PAGE;
    lo_addr = page * WIDTH + c.column;
    hi_addr = lo_addr + WIDTH;
    if (c.func == FN_FILL) begin
      foreach (shadow_frame[i]) shadow_frame[i] = c.value;
    end else if (c.column >= WIDTH || c.row >= ROWS) begin
      r.status = ST_RANGE;
    end else begin
      case (c.func)
        FN_PIXEL: shadow_frame[lo_addr][shift] = c.color;
        FN_GLYPH: begin
          if (shift == 0) begin
            shadow_frame[lo_addr] = c.value;
          end else if (page + 1 >= PAGES) begin
            r.status = ST_RANGE;
          end else begin
            spread    = {8'h00, c.value} << shift;
            keep_mask = 8'hFF >> (8 - shift);
            shadow_frame[lo_addr] = spread[7:0] | (shadow_frame[lo_addr] & keep_mask);
            shadow_frame[hi_addr] = spread[15:8] | (shadow_frame[hi_addr] & ~keep_mask);
          end
        end
        default: r.read_value = shadow_frame[lo_addr];
      endcase
    end
    return r;
  endfunction

  function automatic draw_cmd_t random_draw_cmd();
    draw_cmd_t   c;
    int unsigned pick;
    pick     = $urandom_range(0, 199);
    c.func   = (pick < 2) ? FN_FILL : (pick < 70) ? FN_PIXEL : (pick < 140) ? FN_GLYPH : FN_READ;
    c.column = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 7));
    if (c.func == FN_GLYPH && $urandom_range(0, 4) == 0)
      c.row = 6'($urandom_range(56, 63));
    else
      c.row = 6'($urandom_range(0, 63));
    c.color = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0:       c.value = 8'h00;
      1:       c.value = 8'hFF;
      default: c.value = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  task automatic send_draw_cmd(input draw_cmd_t c, input bit typed,
                               input draw_result_t typed_res);
    draw_result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= c.func;
    in_column <= c.column;
    in_row    <= c.row;
    in_color  <= c.color;
    in_value  <= c.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_draw_cmd(c);
    expected_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // hold out_ready low in random bursts
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    draw_result_t got;
    draw_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{status: out_status, read_value: out_read_value};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d read %02h",
                 $time, got.status, got.read_value);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, got.status);
          error_count++;
        end
        if (got.read_value !== want.read_value) begin
          $display("%0t: read_value mismatch, expected %02h, actual %02h",
                   $time, want.read_value, got.read_value);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    draw_cmd_t    c;
    draw_result_t no_res;
    no_res       = '{status: ST_OK, read_value: 8'h00};
    error_count  = 0;
    stall_cycles = 0;
    idle_on      = 1'b1;
    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = FN_FILL;
    in_column = 7'd0;
    in_row    = 6'd0;
    in_color  = 1'b0;
    in_value  = 8'h00;

    directed_rows = '{
      //   func      col      row    clr   value    typed   status    read
      '{'{FN_READ,  7'd0,   6'd0,  1'b0, 8'h00}, 1'b1, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd127, 6'd63, 1'b1, 8'hFF}, 1'b1, '{ST_OK,    8'h00}},
      '{'{FN_PIXEL, 7'd127, 6'd63, 1'b1, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd127, 6'd63, 1'b0, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_PIXEL, 7'd0,   6'd0,  1'b1, 8'hFF}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd0,   6'd0,  1'b0, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_PIXEL, 7'd0,   6'd0,  1'b0, 8'hFF}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd0,   6'd0,  1'b0, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_GLYPH, 7'd5,   6'd8,  1'b0, 8'hFF}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd5,   6'd8,  1'b0, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_GLYPH, 7'd5,   6'd3,  1'b1, 8'hA5}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd5,   6'd0,  1'b0, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd5,   6'd8,  1'b0, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_GLYPH, 7'd10,  6'd57, 1'b0, 8'hFF}, 1'b1, '{ST_RANGE, 8'h00}},
      '{'{FN_GLYPH, 7'd10,  6'd63, 1'b1, 8'h01}, 1'b1, '{ST_RANGE, 8'h00}},
      '{'{FN_READ,  7'd10,  6'd56, 1'b0, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_GLYPH, 7'd10,  6'd56, 1'b0, 8'h3C}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd10,  6'd63, 1'b0, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_FILL,  7'd127, 6'd63, 1'b1, 8'hFF}, 1'b1, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd64,  6'd32, 1'b0, 8'h00}, 1'b1, '{ST_OK,    8'hFF}},
      '{'{FN_GLYPH, 7'd64,  6'd33, 1'b0, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd64,  6'd32, 1'b0, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd64,  6'd40, 1'b0, 8'h00}, 1'b0, '{ST_OK,    8'h00}},
      '{'{FN_FILL,  7'd85,  6'd42, 1'b0, 8'h00}, 1'b1, '{ST_OK,    8'h00}},
      '{'{FN_READ,  7'd127, 6'd0,  1'b1, 8'hAA}, 1'b1, '{ST_OK,    8'h00}}
    };

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_draw_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].result);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n == RANDOM_CMDS - CALM_TAIL) idle_on = 1'b0;
      c = random_draw_cmd();
      send_draw_cmd(c, 1'b0, no_res);
    end
    in_valid <= 1'b0;

    // drain outstanding results
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
